// ----- rtl/core/mbvi_pkg.sv -----
// Shared constants, codes and control types for the bounded value iteration block.
`timescale 1ns / 1ps
package mbvi_pkg;
    localparam int DefMaxStates  = 1024;
    localparam int DefMaxChoices = 4096;
    localparam int DefMaxTrans   = 16384;

    localparam int ActW     = 3;
    localparam int IdxW     = 14;
    localparam int OffW     = 15;
    localparam int CtW      = OffW + 1;
    localparam int TgtW     = 10;
    localparam int WgtW     = 17;
    localparam int ValW     = 32;
    localparam int KindW    = 2;
    localparam int IterW    = 16;
    localparam int CntW     = 11;
    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 16;

    localparam logic [ActW-1:0] ACT_SOFF = 3'd0;
    localparam logic [ActW-1:0] ACT_COFF = 3'd1;
    localparam logic [ActW-1:0] ACT_TRAN = 3'd2;
    localparam logic [ActW-1:0] ACT_VWR  = 3'd3;
    localparam logic [ActW-1:0] ACT_RUN  = 3'd4;
    localparam logic [ActW-1:0] ACT_VRD  = 3'd5;

    localparam logic [KindW-1:0] KIND_ACK  = 2'd0;
    localparam logic [KindW-1:0] KIND_RUN  = 2'd1;
    localparam logic [KindW-1:0] KIND_READ = 2'd2;

    localparam logic [CfgIdxW-1:0] CFG_BOUND = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_MIN   = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_COUNT = 2'd2;

    localparam logic signed [ValW-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [ValW-1:0] VAL_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic host_acc;
        logic run_init;
        logic iter_start;
        logic so_hi;
        logic ld_cfrom;
        logic ld_cto;
        logic co_hi;
        logic ld_tfrom;
        logic ld_tto;
        logic ld_prod;
        logic acc_add;
        logic choice_end;
        logic s_wr;
        logic iter_end;
        logic out_run;
        logic out_rd;
    } t_cmd;

    typedef struct packed {
        logic n_zero;
        logic s_last;
        logic c_lt;
        logic t_lt;
        logic bound_zero;
        logic it_last;
    } t_sts;
endpackage

// ----- rtl/core/mbvi_if.sv -----
// Channel interfaces: command input, result output and register write.
`timescale 1ns / 1ps
interface mbvi_in_if;
    logic                         valid;
    logic                         ready;
    logic [mbvi_pkg::ActW-1:0]    action;
    logic [mbvi_pkg::IdxW-1:0]    entry_index;
    logic [mbvi_pkg::OffW-1:0]    offset_value;
    logic [mbvi_pkg::TgtW-1:0]    target_state;
    logic [mbvi_pkg::WgtW-1:0]    transition_weight;
    logic signed [mbvi_pkg::ValW-1:0] initial_value;
    modport source (output valid, action, entry_index, offset_value, target_state,
                    transition_weight, initial_value, input ready);
    modport sink (input valid, action, entry_index, offset_value, target_state,
                  transition_weight, initial_value, output ready);
endinterface

interface mbvi_out_if;
    logic                             valid;
    logic                             ready;
    logic [mbvi_pkg::KindW-1:0]       result_kind;
    logic signed [mbvi_pkg::ValW-1:0] state_value;
    logic [mbvi_pkg::IterW-1:0]       iterations_reported;
    modport source (output valid, result_kind, state_value, iterations_reported,
                    input ready);
    modport sink (input valid, result_kind, state_value, iterations_reported,
                  output ready);
endinterface

interface mbvi_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [mbvi_pkg::CfgIdxW-1:0]   index;
    logic [mbvi_pkg::CfgDataW-1:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/mbvi_ctrl.sv -----
// Sequencer for loads, reads and value iteration sweeps.
`timescale 1ns / 1ps
module mbvi_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic [mbvi_pkg::ActW-1:0] i_action,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output mbvi_pkg::t_cmd        o_cmd,
    input  mbvi_pkg::t_sts        i_sts
);
    import mbvi_pkg::*;

    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_RD     = 5'd1;
    localparam logic [4:0] ST_RINIT  = 5'd2;
    localparam logic [4:0] ST_SSTART = 5'd3;
    localparam logic [4:0] ST_SA     = 5'd4;
    localparam logic [4:0] ST_SB     = 5'd5;
    localparam logic [4:0] ST_SC     = 5'd6;
    localparam logic [4:0] ST_CCHK   = 5'd7;
    localparam logic [4:0] ST_CB     = 5'd8;
    localparam logic [4:0] ST_CC     = 5'd9;
    localparam logic [4:0] ST_TCHK   = 5'd10;
    localparam logic [4:0] ST_TB     = 5'd11;
    localparam logic [4:0] ST_TC     = 5'd12;
    localparam logic [4:0] ST_TD     = 5'd13;
    localparam logic [4:0] ST_SWR    = 5'd14;
    localparam logic [4:0] ST_IEND   = 5'd15;
    localparam logic [4:0] ST_FIN    = 5'd16;

    logic [4:0] r_state, n_state;
    logic       r_ovalid, n_ovalid;
    logic       slot_free;
    logic       host_acc;
    logic       ack_load;

    assign slot_free  = !r_ovalid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE) && slot_free;
    assign host_acc   = i_in_valid && o_in_ready;
    assign ack_load   = host_acc && (i_action != ACT_RUN) && (i_action != ACT_VRD);
    assign o_out_valid = r_ovalid;

    // Decode state into datapath commands and next state
    always_comb begin
        o_cmd          = '0;
        n_state        = r_state;
        o_cmd.host_acc = host_acc;
        case (r_state)
            ST_IDLE: begin
                if (host_acc) begin
                    if (i_action == ACT_VRD) n_state = ST_RD;
                    else if (i_action == ACT_RUN) n_state = ST_RINIT;
                end
            end
            ST_RD: begin
                if (slot_free) begin
                    o_cmd.out_rd = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            ST_RINIT: begin
                o_cmd.run_init = 1'b1;
                n_state = i_sts.bound_zero ? ST_FIN : ST_SSTART;
            end
            ST_SSTART: begin
                o_cmd.iter_start = 1'b1;
                n_state = i_sts.n_zero ? ST_IEND : ST_SA;
            end
            ST_SA: n_state = ST_SB;
            ST_SB: begin
                o_cmd.ld_cfrom = 1'b1;
                o_cmd.so_hi    = 1'b1;
                n_state        = ST_SC;
            end
            ST_SC: begin
                o_cmd.ld_cto = 1'b1;
                n_state      = ST_CCHK;
            end
            ST_CCHK: n_state = i_sts.c_lt ? ST_CB : ST_SWR;
            ST_CB: begin
                o_cmd.ld_tfrom = 1'b1;
                o_cmd.co_hi    = 1'b1;
                n_state        = ST_CC;
            end
            ST_CC: begin
                o_cmd.ld_tto = 1'b1;
                n_state      = ST_TCHK;
            end
            ST_TCHK: begin
                if (i_sts.t_lt) begin
                    n_state = ST_TB;
                end else begin
                    o_cmd.choice_end = 1'b1;
                    n_state          = ST_CCHK;
                end
            end
            ST_TB: n_state = ST_TC;
            ST_TC: begin
                o_cmd.ld_prod = 1'b1;
                n_state       = ST_TD;
            end
            ST_TD: begin
                o_cmd.acc_add = 1'b1;
                n_state       = ST_TCHK;
            end
            ST_SWR: begin
                o_cmd.s_wr = 1'b1;
                n_state    = i_sts.s_last ? ST_IEND : ST_SA;
            end
            ST_IEND: begin
                o_cmd.iter_end = 1'b1;
                n_state = i_sts.it_last ? ST_FIN : ST_SSTART;
            end
            ST_FIN: begin
                if (slot_free) begin
                    o_cmd.out_run = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Hold the result slot until the transaction completes
    always_comb begin
        n_ovalid = r_ovalid;
        if (ack_load || o_cmd.out_rd || o_cmd.out_run) n_ovalid = 1'b1;
        else if (i_out_ready) n_ovalid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (r_state == ST_IDLE))
        else $error("input ready outside idle");
    a_run_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (host_acc && i_action == ACT_RUN) |=> (r_state == ST_RINIT))
        else $error("run command did not start sweeps");
    a_fin_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN && slot_free) |=> (r_ovalid && r_state == ST_IDLE))
        else $error("run result not presented");
endmodule

// ----- rtl/core/mbvi_dp.sv -----
// Datapath: tables, value banks, loop counters, weighted sum and min/max.
`timescale 1ns / 1ps
module mbvi_dp #(
    parameter int MAX_STATES      = mbvi_pkg::DefMaxStates,
    parameter int MAX_CHOICES     = mbvi_pkg::DefMaxChoices,
    parameter int MAX_TRANSITIONS = mbvi_pkg::DefMaxTrans
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [mbvi_pkg::ActW-1:0]          i_action,
    input  logic [mbvi_pkg::IdxW-1:0]          i_idx,
    input  logic [mbvi_pkg::OffW-1:0]          i_offset,
    input  logic [mbvi_pkg::TgtW-1:0]          i_target,
    input  logic [mbvi_pkg::WgtW-1:0]          i_weight,
    input  logic signed [mbvi_pkg::ValW-1:0]   i_init,
    input  logic                               i_cfg_wr,
    input  logic [mbvi_pkg::CfgIdxW-1:0]       i_cfg_idx,
    input  logic [mbvi_pkg::CfgDataW-1:0]      i_cfg_data,
    input  mbvi_pkg::t_cmd                     i_cmd,
    output mbvi_pkg::t_sts                     o_sts,
    output logic [mbvi_pkg::KindW-1:0]         o_kind,
    output logic signed [mbvi_pkg::ValW-1:0]   o_value,
    output logic [mbvi_pkg::IterW-1:0]         o_iters
);
    import mbvi_pkg::*;

    localparam int SoDepth = MAX_STATES + 1;
    localparam int CoDepth = MAX_CHOICES + 1;
    localparam int SoAW    = $clog2(MAX_STATES + 1);
    localparam int CoAW    = $clog2(MAX_CHOICES + 1);
    localparam int TAW     = $clog2(MAX_TRANSITIONS);
    localparam int VAW     = $clog2(MAX_STATES);
    localparam int SW      = SoAW;

    // Configuration registers
    logic [IterW-1:0] r_bound;
    logic             r_min;
    logic [CntW-1:0]  r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bound <= '0;
            r_min   <= 1'b0;
            r_count <= '0;
        end else if (i_cfg_wr) begin
            case (i_cfg_idx)
                CFG_BOUND: r_bound <= i_cfg_data;
                CFG_MIN:   r_min   <= i_cfg_data[0];
                CFG_COUNT: r_count <= i_cfg_data[CntW-1:0];
                default: ;
            endcase
        end
    end

    // Host write decode
    logic [31:0] idx32;
    logic        wr_so, wr_co, wr_tr, wr_v;
    assign idx32 = 32'(i_idx);
    assign wr_so = i_cmd.host_acc && (i_action == ACT_SOFF) && (idx32 < 32'(SoDepth));
    assign wr_co = i_cmd.host_acc && (i_action == ACT_COFF) && (idx32 < 32'(CoDepth));
    assign wr_tr = i_cmd.host_acc && (i_action == ACT_TRAN)
                   && (idx32 < 32'(MAX_TRANSITIONS));
    assign wr_v  = i_cmd.host_acc && (i_action == ACT_VWR) && (idx32 < 32'(MAX_STATES));

    // Loop registers
    logic [SW-1:0]    r_s;
    logic [CtW-1:0]   r_c, r_cto, r_t, r_tto;
    logic [IterW-1:0] r_it, r_last;
    logic             r_bank;
    logic signed [ValW-1:0] r_acc, r_best;
    logic signed [49:0]     r_prod;
    logic             r_tgt_ok, r_rd_ok;

    // State offset table
    logic [OffW-1:0] so_mem [SoDepth];
    logic [OffW-1:0] r_so_q;
    logic [SoAW-1:0] so_addr;
    assign so_addr = i_cmd.so_hi ? SoAW'(r_s + SW'(1)) : SoAW'(r_s);
    always_ff @(posedge i_clk) begin
        if (wr_so) so_mem[SoAW'(i_idx)] <= i_offset;
        r_so_q <= so_mem[so_addr];
    end

    // Choice offset table
    logic [OffW-1:0] co_mem [CoDepth];
    logic [OffW-1:0] r_co_q;
    logic [CoAW-1:0] co_addr;
    assign co_addr = i_cmd.co_hi ? CoAW'(r_c + CtW'(1)) : CoAW'(r_c);
    always_ff @(posedge i_clk) begin
        if (wr_co) co_mem[CoAW'(i_idx)] <= i_offset;
        r_co_q <= co_mem[co_addr];
    end

    // Transition tables
    logic [TgtW-1:0] tgt_mem [MAX_TRANSITIONS];
    logic [WgtW-1:0] wgt_mem [MAX_TRANSITIONS];
    logic [TgtW-1:0] r_tgt_q;
    logic [WgtW-1:0] r_wgt_q;
    always_ff @(posedge i_clk) begin
        if (wr_tr) begin
            tgt_mem[TAW'(i_idx)] <= i_target;
            wgt_mem[TAW'(i_idx)] <= i_weight;
        end
        r_tgt_q <= tgt_mem[TAW'(r_t)];
        r_wgt_q <= wgt_mem[TAW'(r_t)];
    end

    // Value banks: host accesses the current bank, a sweep writes the other one
    logic signed [ValW-1:0] va_mem [MAX_STATES];
    logic signed [ValW-1:0] vb_mem [MAX_STATES];
    logic signed [ValW-1:0] r_va_q, r_vb_q, v_cur, wdata;
    logic [VAW-1:0] vaddr, waddr;
    logic           wa_en, wb_en;
    assign vaddr = i_cmd.host_acc ? VAW'(i_idx) : VAW'(r_tgt_q);
    assign waddr = i_cmd.s_wr ? VAW'(r_s) : VAW'(i_idx);
    assign wdata = i_cmd.s_wr ? r_best : i_init;
    assign wa_en = (wr_v && !r_bank) || (i_cmd.s_wr && r_bank);
    assign wb_en = (wr_v && r_bank) || (i_cmd.s_wr && !r_bank);
    assign v_cur = r_bank ? r_vb_q : r_va_q;
    always_ff @(posedge i_clk) begin
        if (wa_en) va_mem[waddr] <= wdata;
        if (wb_en) vb_mem[waddr] <= wdata;
        r_va_q <= va_mem[vaddr];
        r_vb_q <= vb_mem[vaddr];
    end

    // Clamp loaded offsets to table sizes
    logic [CtW-1:0] cto_clamp, tto_clamp;
    assign cto_clamp = (32'(r_so_q) > 32'(MAX_CHOICES)) ? CtW'(MAX_CHOICES) : CtW'(r_so_q);
    assign tto_clamp = (32'(r_co_q) > 32'(MAX_TRANSITIONS)) ?
                       CtW'(MAX_TRANSITIONS) : CtW'(r_co_q);

    // Saturating accumulate of the truncated product
    logic signed [33:0] prod_sh;
    logic signed [34:0] sum;
    logic signed [ValW-1:0] sum_sat;
    assign prod_sh = r_prod[49:16];
    assign sum     = {{3{r_acc[ValW-1]}}, r_acc} + {prod_sh[33], prod_sh};
    always_comb begin
        if (sum > 35'sh0_7FFF_FFFF) sum_sat = VAL_MAX;
        else if (sum < -35'sh0_8000_0000) sum_sat = VAL_MIN;
        else sum_sat = sum[ValW-1:0];
    end

    logic signed [ValW-1:0] v_succ;
    logic                   better;
    assign v_succ = r_tgt_ok ? v_cur : '0;
    assign better = r_min ? (r_acc < r_best) : (r_acc > r_best);

    always_ff @(posedge i_clk) begin
        r_tgt_ok <= (32'(r_tgt_q) < 32'(MAX_STATES));
        if (i_cmd.host_acc) r_rd_ok <= (idx32 < 32'(MAX_STATES));
        if (i_cmd.iter_start) r_s <= '0;
        if (i_cmd.s_wr) r_s <= r_s + SW'(1);
        if (i_cmd.ld_cfrom) r_c <= CtW'(r_so_q);
        if (i_cmd.ld_cto) begin
            r_cto  <= cto_clamp;
            r_best <= r_min ? VAL_MAX : VAL_MIN;
        end
        if (i_cmd.ld_tfrom) r_t <= CtW'(r_co_q);
        if (i_cmd.ld_tto) begin
            r_tto <= tto_clamp;
            r_acc <= '0;
        end
        if (i_cmd.ld_prod) r_prod <= $signed({1'b0, r_wgt_q}) * v_succ;
        if (i_cmd.acc_add) begin
            r_acc <= sum_sat;
            r_t   <= r_t + CtW'(1);
        end
        if (i_cmd.choice_end) begin
            if (better) r_best <= r_acc;
            r_c <= r_c + CtW'(1);
        end
        if (i_cmd.run_init) r_it <= '0;
        if (i_cmd.iter_end) r_it <= r_it + IterW'(1);
    end

    // Control state that survives between runs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank <= 1'b0;
            r_last <= '0;
        end else begin
            if (i_cmd.run_init) r_last <= '0;
            if (i_cmd.iter_end) begin
                r_last <= r_it;
                r_bank <= ~r_bank;
            end
        end
    end

    // Status back to the sequencer
    logic [SW-1:0] n_states;
    assign n_states = (32'(r_count) > 32'(MAX_STATES)) ? SW'(MAX_STATES) : SW'(r_count);
    assign o_sts.n_zero     = (n_states == '0);
    assign o_sts.s_last     = ({1'b0, r_s} + (SW+1)'(1)) >= {1'b0, n_states};
    assign o_sts.c_lt       = r_c < r_cto;
    assign o_sts.t_lt       = r_t < r_tto;
    assign o_sts.bound_zero = (r_bound == '0);
    assign o_sts.it_last    = ({1'b0, r_it} + (IterW+1)'(1)) >= {1'b0, r_bound};

    // Result register
    logic [KindW-1:0]       r_kind;
    logic signed [ValW-1:0] r_val;
    logic [IterW-1:0]       r_iters;
    always_ff @(posedge i_clk) begin
        if (i_cmd.host_acc && (i_action != ACT_RUN) && (i_action != ACT_VRD)) begin
            r_kind  <= KIND_ACK;
            r_val   <= '0;
            r_iters <= '0;
        end else if (i_cmd.out_rd) begin
            r_kind  <= KIND_READ;
            r_val   <= r_rd_ok ? v_cur : '0;
            r_iters <= '0;
        end else if (i_cmd.out_run) begin
            r_kind  <= KIND_RUN;
            r_val   <= '0;
            r_iters <= r_last;
        end
    end
    assign o_kind  = r_kind;
    assign o_value = r_val;
    assign o_iters = r_iters;
endmodule

// ----- rtl/core/mdp_bounded_value_iteration.sv -----
// A table or value write is answered in the cycle after it, a read once the result slot is free.
// Load and write transactions are taken one per cycle while the result slot drains.
// A run makes bound sweeps, each stepping through every state, choice and transition in turn
// on the one shared multiply-accumulate and the single table read ports.
// Synchronous active-low reset clears the sequencer, config, bank select and reported count;
// the tables and value banks are not cleared and hold nothing defined until written.
`timescale 1ns / 1ps
module mdp_bounded_value_iteration #(
    parameter int MAX_STATES      = mbvi_pkg::DefMaxStates,
    parameter int MAX_CHOICES     = mbvi_pkg::DefMaxChoices,
    parameter int MAX_TRANSITIONS = mbvi_pkg::DefMaxTrans
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mbvi_in_if.sink       i_in,
    mbvi_out_if.source    o_res,
    mbvi_cfg_if.sink      i_cfg
);
    import mbvi_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic in_ready;
    logic out_valid;

    assign i_in.ready  = in_ready;
    assign i_cfg.ready = 1'b1;
    assign o_res.valid = out_valid;

    // Sequencer
    mbvi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_action    (i_in.action),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_res.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // Tables and arithmetic
    mbvi_dp #(
        .MAX_STATES      (MAX_STATES),
        .MAX_CHOICES     (MAX_CHOICES),
        .MAX_TRANSITIONS (MAX_TRANSITIONS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_action   (i_in.action),
        .i_idx      (i_in.entry_index),
        .i_offset   (i_in.offset_value),
        .i_target   (i_in.target_state),
        .i_weight   (i_in.transition_weight),
        .i_init     (i_in.initial_value),
        .i_cfg_wr   (i_cfg.valid),
        .i_cfg_idx  (i_cfg.index),
        .i_cfg_data (i_cfg.data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_kind     (o_res.result_kind),
        .o_value    (o_res.state_value),
        .o_iters    (o_res.iterations_reported)
    );
endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the bounded value iteration block.
`timescale 1ns / 1ps
module tb;
    import mbvi_pkg::*;

    localparam logic [ActW-1:0] ACT_SPARE6 = 3'd6;
    localparam logic [ActW-1:0] ACT_SPARE7 = 3'd7;
    localparam int ITEM_TARGET = 1550;
    localparam int STALL_LIMIT = 600000;

    typedef struct packed {
        logic [ActW-1:0]        act;
        logic [IdxW-1:0]        idx;
        logic [OffW-1:0]        off;
        logic [TgtW-1:0]        tgt;
        logic [WgtW-1:0]        wgt;
        logic signed [ValW-1:0] val;
    } cmd_t;

    typedef struct packed {
        logic [KindW-1:0]       kind;
        logic signed [ValW-1:0] val;
        logic [IterW-1:0]       iter;
    } res_t;

    typedef struct packed {
        cmd_t cmd;
        logic typed;
        res_t res;
    } dir_row_t;

    localparam res_t ACK = {KIND_ACK, 32'sd0, 16'd0};

    logic i_clk;
    logic i_rst_n;
    mbvi_in_if  in_ch ();
    mbvi_out_if res_ch ();
    mbvi_cfg_if cfg_ch ();

    mdp_bounded_value_iteration dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    // Mirror of the block's tables, value banks and registers
    logic [OffW-1:0]        soff_m [0:DefMaxStates];
    logic [OffW-1:0]        coff_m [0:DefMaxChoices];
    logic [TgtW-1:0]        tgt_m  [0:DefMaxTrans-1];
    logic [WgtW-1:0]        wgt_m  [0:DefMaxTrans-1];
    logic signed [ValW-1:0] bank_m [2][DefMaxStates];
    bit                     cur_bank;
    logic [IterW-1:0]       last_iter;
    logic [15:0]            bound_r;
    bit                     min_r;
    logic [CntW-1:0]        count_r;

    res_t expected_q [$];
    int   errors;
    int   items_sent;
    bit   quiet;
    int   stall_cnt;

    function automatic logic signed [ValW-1:0] sat32(longint x);
        if (x > longint'(32'sh7FFF_FFFF)) return VAL_MAX;
        if (x < -longint'(64'h8000_0000)) return VAL_MIN;
        return x[31:0];
    endfunction

    // One bounded value iteration run over the mirrored tables
    function automatic void sweep_model();
        int n, it, s, c, t, cf, ct, tf, tt;
        bit p;
        logic signed [ValW-1:0] best, acc, v;
        longint pw, pv;
        n = (count_r > DefMaxStates) ? DefMaxStates : count_r;
        last_iter = '0;
        for (it = 0; it < bound_r; it++) begin
            p = cur_bank;
            for (s = 0; s < n; s++) begin
                cf = soff_m[s];
                ct = soff_m[s+1];
                if (ct > DefMaxChoices) ct = DefMaxChoices;
                best = min_r ? VAL_MAX : VAL_MIN;
                for (c = cf; c < ct; c++) begin
                    tf = coff_m[c];
                    tt = coff_m[c+1];
                    if (tt > DefMaxTrans) tt = DefMaxTrans;
                    acc = '0;
                    for (t = tf; t < tt; t++) begin
                        v  = bank_m[p][tgt_m[t]];
                        pw = wgt_m[t];
                        pv = v;
                        acc = sat32(longint'(acc) + ((pw * pv) >>> 16));
                    end
                    if (min_r ? (acc < best) : (acc > best)) best = acc;
                end
                bank_m[!p][s] = best;
            end
            last_iter = it[15:0];
            cur_bank = !cur_bank;
        end
    endfunction

    function automatic res_t value_step(cmd_t c);
        res_t r;
        r = ACK;
        case (c.act)
            ACT_SOFF: if (c.idx <= DefMaxStates) soff_m[c.idx] = c.off;
            ACT_COFF: if (c.idx <= DefMaxChoices) coff_m[c.idx] = c.off;
            ACT_TRAN: begin
                tgt_m[c.idx] = c.tgt;
                wgt_m[c.idx] = c.wgt;
            end
            ACT_VWR:  if (c.idx < DefMaxStates) bank_m[cur_bank][c.idx] = c.val;
            ACT_RUN: begin
                sweep_model();
                r.kind = KIND_RUN;
                r.iter = last_iter;
            end
            ACT_VRD: begin
                r.kind = KIND_READ;
                if (c.idx < DefMaxStates) r.val = bank_m[cur_bank][c.idx];
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic cmd_t mk(logic [ActW-1:0] act, int idx, int off, int tg, int w,
                                logic signed [ValW-1:0] val);
        cmd_t c;
        c.act = act;
        c.idx = idx[IdxW-1:0];
        c.off = off[OffW-1:0];
        c.tgt = tg[TgtW-1:0];
        c.wgt = w[WgtW-1:0];
        c.val = val;
        return c;
    endfunction

    function automatic cmd_t rand_cmd(logic [ActW-1:0] act);
        return mk(act, $urandom, $urandom, $urandom, $urandom, $urandom);
    endfunction

    function automatic logic signed [ValW-1:0] rand_val();
        case ($urandom_range(5))
            0: return VAL_MAX;
            1: return VAL_MIN;
            2: return 32'sd0;
            default: return $urandom;
        endcase
    endfunction

    function automatic int rand_wgt();
        case ($urandom_range(7))
            0, 1: return 65536;
            2: return 0;
            default: return $urandom_range(0, 65536);
        endcase
    endfunction

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Result side: random backpressure, none in quiet stretches
    always @(posedge i_clk) begin
        res_ch.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 25);
    end

    // Check each result transaction against the oldest expectation
    always @(posedge i_clk) begin
        res_t e;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (expected_q.size() == 0) begin
                $error("unexpected result: kind %0d", res_ch.result_kind);
                errors++;
            end else begin
                e = expected_q.pop_front();
                if (res_ch.result_kind !== e.kind) begin
                    $error("result_kind: expected %0d, got %0d", e.kind, res_ch.result_kind);
                    errors++;
                end
                if (res_ch.state_value !== e.val) begin
                    $error("state_value: expected %0h, got %0h", e.val, res_ch.state_value);
                    errors++;
                end
                if (res_ch.iterations_reported !== e.iter) begin
                    $error("iterations_reported: expected %0d, got %0d", e.iter,
                           res_ch.iterations_reported);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no transaction on any channel
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    // Send one command, predict its result on acceptance
    task automatic send(cmd_t c, bit typed, res_t te);
        res_t r;
        if (!quiet && $urandom_range(99) < 20) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        in_ch.valid             <= 1'b1;
        in_ch.action            <= c.act;
        in_ch.entry_index       <= c.idx;
        in_ch.offset_value      <= c.off;
        in_ch.target_state      <= c.tgt;
        in_ch.transition_weight <= c.wgt;
        in_ch.initial_value     <= c.val;
        do @(posedge i_clk); while (!in_ch.ready);
        r = value_step(c);
        expected_q.push_back(typed ? te : r);
        items_sent++;
    endtask

    // Hold until every expected result has come, then let the block settle
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic reg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            CFG_BOUND: bound_r = data;
            CFG_MIN:   min_r   = data[0];
            CFG_COUNT: count_r = data[CntW-1:0];
            default: ;
        endcase
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Load a small well-formed model, then mix runs, reads, value writes, noise writes and spare actions
    task automatic random_phase(int n);
        int nc, nt, ci, ti, s, c, k, m, r, sel;
        int ch_cnt [$];
        drain();
        reg_write(CFG_BOUND, ($urandom_range(99) < 15) ? 16'd0 : 16'($urandom_range(1, 12)));
        reg_write(CFG_MIN, 16'($urandom));
        reg_write(CFG_COUNT, 16'(n));
        ci = 0;
        send(mk(ACT_SOFF, 0, 0, $urandom, $urandom, $urandom), 1'b0, ACK);
        for (s = 0; s < n; s++) begin
            nc = ($urandom_range(99) < 20) ? 0 : $urandom_range(1, 3);
            ci += nc;
            send(mk(ACT_SOFF, s + 1, ci, $urandom, $urandom, $urandom), 1'b0, ACK);
        end
        ti = 0;
        send(mk(ACT_COFF, 0, 0, $urandom, $urandom, $urandom), 1'b0, ACK);
        for (c = 0; c < ci; c++) begin
            nt = ($urandom_range(99) < 10) ? 0 : $urandom_range(1, 3);
            ti += nt;
            send(mk(ACT_COFF, c + 1, ti, $urandom, $urandom, $urandom), 1'b0, ACK);
        end
        for (k = 0; k < ti; k++)
            send(mk(ACT_TRAN, k, $urandom, $urandom_range(0, n - 1), rand_wgt(), $urandom),
                 1'b0, ACK);
        for (s = 0; s < n; s++)
            send(mk(ACT_VWR, s, $urandom, $urandom, $urandom, rand_val()), 1'b0, ACK);
        m = $urandom_range(20, 60);
        for (k = 0; k < m; k++) begin
            r = $urandom_range(99);
            if (r < 8) begin
                send(rand_cmd(ACT_RUN), 1'b0, ACK);
            end else if (r < 38) begin
                sel = ($urandom_range(9) == 0) ? $urandom_range(DefMaxStates, 16383)
                                               : $urandom_range(0, n - 1);
                send(mk(ACT_VRD, sel, $urandom, $urandom, $urandom, $urandom), 1'b0, ACK);
            end else if (r < 58) begin
                sel = ($urandom_range(4) == 0) ? $urandom_range(n, 16383)
                                               : $urandom_range(0, n - 1);
                send(mk(ACT_VWR, sel, $urandom, $urandom, $urandom, rand_val()), 1'b0, ACK);
            end else if (r < 93) begin
                case ($urandom_range(2))
                    0: send(mk(ACT_SOFF, $urandom_range(n + 1, 16383), $urandom, $urandom,
                               $urandom, $urandom), 1'b0, ACK);
                    1: send(mk(ACT_COFF, $urandom_range(ci + 1, 16383), $urandom, $urandom,
                               $urandom, $urandom), 1'b0, ACK);
                    default: send(mk(ACT_TRAN, $urandom_range(ti, 16383), $urandom, $urandom,
                                     rand_wgt(), $urandom), 1'b0, ACK);
                endcase
            end else begin
                send(rand_cmd($urandom_range(1) ? ACT_SPARE6 : ACT_SPARE7), 1'b0, ACK);
            end
        end
    endtask

    // Stimulus: directed table, extreme settings, then random model phases
    initial begin
        dir_row_t rows [$];
        int phase;
        errors = 0;
        items_sent = 0;
        quiet = 1'b0;
        stall_cnt = 0;
        cur_bank = 1'b0;
        last_iter = '0;
        bound_r = '0;
        min_r = 1'b0;
        count_r = '0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.action = '0;
        in_ch.entry_index = '0;
        in_ch.offset_value = '0;
        in_ch.target_state = '0;
        in_ch.transition_weight = '0;
        in_ch.initial_value = '0;
        res_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        reg_write(CFG_BOUND, 16'd1);
        reg_write(CFG_MIN, 16'd1);
        reg_write(CFG_COUNT, 16'd2);

        // State 0: one choice cut at the table end, one transition cut likewise.
        // State 1: reversed choice range, so no choices.
        rows.push_back({mk(ACT_SOFF, 0, 4095, 0, 0, 0), 1'b1, ACK});
        rows.push_back({mk(ACT_SOFF, 1, 32767, 0, 0, 0), 1'b1, ACK});
        rows.push_back({mk(ACT_SOFF, 2, 0, 0, 0, 0), 1'b1, ACK});
        rows.push_back({mk(ACT_COFF, 4095, 16383, 0, 0, 0), 1'b1, ACK});
        rows.push_back({mk(ACT_COFF, 4096, 32767, 0, 0, 0), 1'b1, ACK});
        rows.push_back({mk(ACT_TRAN, 16383, 0, 0, 65536, 0), 1'b1, ACK});
        rows.push_back({mk(ACT_VWR, 0, 0, 0, 0, VAL_MIN), 1'b1, ACK});
        rows.push_back({mk(ACT_VWR, 1, 0, 1023, 0, VAL_MAX), 1'b1, ACK});
        rows.push_back({mk(ACT_VRD, 0, 0, 0, 0, 0), 1'b1, res_t'({KIND_READ, VAL_MIN, 16'd0})});
        rows.push_back({mk(ACT_VRD, 16383, 0, 0, 0, 0), 1'b1, res_t'({KIND_READ, 32'sd0, 16'd0})});
        rows.push_back({mk(ACT_VWR, 16383, 0, 0, 0, VAL_MAX), 1'b1, ACK});
        rows.push_back({mk(ACT_SOFF, 16383, 32767, 0, 0, 0), 1'b1, ACK});
        rows.push_back({mk(ACT_COFF, 16383, 32767, 0, 0, 0), 1'b1, ACK});
        rows.push_back({mk(ACT_SPARE6, 16383, 32767, 1023, 131071, -1), 1'b1, ACK});
        rows.push_back({mk(ACT_SPARE7, 0, 0, 0, 0, 0), 1'b1, ACK});
        rows.push_back({mk(ACT_RUN, 0, 0, 0, 0, 0), 1'b0, ACK});
        rows.push_back({mk(ACT_VRD, 0, 0, 0, 0, 0), 1'b0, ACK});
        rows.push_back({mk(ACT_VRD, 1, 0, 0, 0, 0), 1'b1, res_t'({KIND_READ, VAL_MAX, 16'd0})});
        rows.push_back({mk(ACT_RUN, 0, 0, 0, 0, 0), 1'b0, ACK});
        rows.push_back({mk(ACT_VRD, 0, 0, 0, 0, 0), 1'b0, ACK});
        rows.push_back({mk(ACT_VRD, 1, 0, 0, 0, 0), 1'b1, res_t'({KIND_READ, VAL_MAX, 16'd0})});
        foreach (rows[i]) send(rows[i].cmd, rows[i].typed, rows[i].res);

        // Oversized state count with no sweeps, then the longest run on no states
        drain();
        reg_write(CFG_COUNT, 16'hFFFF);
        reg_write(CFG_BOUND, 16'd0);
        reg_write(CFG_MIN, 16'hFFFE);
        send(mk(ACT_RUN, 0, 0, 0, 0, 0), 1'b1, res_t'({KIND_RUN, 32'sd0, 16'd0}));
        drain();
        reg_write(CFG_COUNT, 16'd0);
        reg_write(CFG_BOUND, 16'hFFFF);
        send(mk(ACT_RUN, 0, 0, 0, 0, 0), 1'b1, res_t'({KIND_RUN, 32'sd0, 16'd65534}));

        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            quiet = (phase >= 6 && phase <= 8);
            random_phase($urandom_range(1, 8));
            phase++;
        end
        quiet = 1'b0;
        drain();
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
